FILE: design/phld_pkg.sv
// Shared types, constants and helper functions for the prefixed hex line decoder.
`default_nettype none

package phld_pkg;

    // Line capacity, limited so that the byte count fits in its field.
    localparam int MAX_BYTES   = 1280;
    localparam int COUNT_LIMIT = 2047;
    localparam int CAPACITY    = (MAX_BYTES > COUNT_LIMIT) ? COUNT_LIMIT : MAX_BYTES;

    localparam int COUNT_W   = 11;
    localparam int TAG_LEN   = 8;
    localparam int TAG_POS_W = 4;

    localparam logic [COUNT_W-1:0]   CAPACITY_C = COUNT_W'(CAPACITY);
    localparam logic [TAG_POS_W-1:0] TAG_LEN_C  = TAG_POS_W'(TAG_LEN);

    // Kind of a result beat.
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Line status codes.
    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_TAG_MISSING = 3'd1,
        ST_ODD_DIGITS  = 3'd2,
        ST_BAD_DIGIT   = 3'd3,
        ST_OVERFLOW    = 3'd4
    } t_status;

    // One input beat as held in the input register.
    typedef struct packed {
        logic [7:0] char_code;
        logic       line_end;
    } t_char_beat;

    // Expected tag character at a given tag position.
    function automatic logic [7:0] tag_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h43; // C
            3'd1:    c = 8'h4F; // O
            3'd2:    c = 8'h41; // A
            3'd3:    c = 8'h50; // P
            3'd4:    c = 8'h48; // H
            3'd5:    c = 8'h45; // E
            3'd6:    c = 8'h58; // X
            default: c = 8'h3A; // colon
        endcase
        return c;
    endfunction

    // Hex digit value; the top bit flags a character that is not a hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b0, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = {1'b0, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = {1'b0, 4'(c - 8'h37)};
        end else begin
            v = 5'h10;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: design/phld_in_stage.sv
// Input register stage of the prefixed hex line decoder.
`default_nettype none

module phld_in_stage
    import phld_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [7:0] i_char_code,
    input  wire logic       i_line_end,
    output logic            o_in_ready,
    input  wire logic       i_advance,
    output logic            o_beat_valid,
    output t_char_beat      o_beat
);

    logic       r_valid;
    logic       n_valid;
    t_char_beat r_beat;

    // The register can take a beat when empty or when its beat moves on.
    assign o_in_ready = !r_valid || i_advance;

    always_comb begin
        n_valid = r_valid;
        if (i_in_valid && o_in_ready) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload capture.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_beat.char_code <= i_char_code;
            r_beat.line_end  <= i_line_end;
        end
    end

    assign o_beat_valid = r_valid;
    assign o_beat       = r_beat;

endmodule

`default_nettype wire

FILE: design/phld_decode.sv
// Line state, hex pair decode and result register of the prefixed hex line decoder.
`default_nettype none

module phld_decode
    import phld_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_beat_valid,
    input  wire t_char_beat i_beat,
    output logic            o_advance,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic            o_kind,
    output logic [7:0]      o_data_byte,
    output logic [2:0]      o_status,
    output logic [COUNT_W-1:0] o_byte_count
);

    // Line state.
    logic [TAG_POS_W-1:0] r_tag_pos,   n_tag_pos;
    logic                 r_mismatch,  n_mismatch;
    logic [3:0]           r_held,      n_held;
    logic                 r_pending,   n_pending;
    logic                 r_dig_err,   n_dig_err;
    logic                 r_cap_ex,    n_cap_ex;
    logic [COUNT_W-1:0]   r_count,     n_count;

    // Result register.
    logic                 r_out_valid, n_out_valid;
    logic                 r_kind,      n_kind;
    logic [7:0]           r_data,      n_data;
    t_status              r_status,    n_status;
    logic [COUNT_W-1:0]   r_bcount,    n_bcount;

    logic                 emit;
    logic [4:0]           hv;

    // A beat moves on whenever the result register is free or being emptied.
    assign o_advance = i_beat_valid && (!r_out_valid || i_out_ready);
    assign hv        = hex_value(i_beat.char_code);

    // Next line state and result.
    always_comb begin
        n_tag_pos  = r_tag_pos;
        n_mismatch = r_mismatch;
        n_held     = r_held;
        n_pending  = r_pending;
        n_dig_err  = r_dig_err;
        n_cap_ex   = r_cap_ex;
        n_count    = r_count;
        emit       = 1'b0;
        n_kind     = KIND_DATA;
        n_data     = 8'h00;
        n_status   = ST_OK;
        n_bcount   = '0;

        if (o_advance) begin
            if (i_beat.line_end) begin
                // Judge the line, then clear it.
                emit     = 1'b1;
                n_kind   = KIND_STATUS;
                n_bcount = r_count;
                if (r_tag_pos < TAG_LEN_C || r_mismatch) begin
                    n_status = ST_TAG_MISSING;
                end else if (r_pending) begin
                    n_status = ST_ODD_DIGITS;
                end else if (r_dig_err) begin
                    n_status = ST_BAD_DIGIT;
                end else if (r_cap_ex) begin
                    n_status = ST_OVERFLOW;
                end else begin
                    n_status = ST_OK;
                end
                n_tag_pos  = '0;
                n_mismatch = 1'b0;
                n_held     = 4'h0;
                n_pending  = 1'b0;
                n_dig_err  = 1'b0;
                n_cap_ex   = 1'b0;
                n_count    = '0;
            end else if (r_tag_pos < TAG_LEN_C) begin
                // Tag comparison.
                if (i_beat.char_code != tag_char(r_tag_pos[2:0])) begin
                    n_mismatch = 1'b1;
                end
                n_tag_pos = r_tag_pos + 1'b1;
            end else if (!r_mismatch) begin
                // Payload digits: parity always toggles.
                n_pending = !r_pending;
                if (!r_dig_err) begin
                    if (hv[4]) begin
                        n_dig_err = 1'b1;
                    end else if (!r_pending) begin
                        n_held = hv[3:0];
                    end else if (r_cap_ex || r_count >= CAPACITY_C) begin
                        n_cap_ex = 1'b1;
                    end else begin
                        n_count = r_count + 1'b1;
                        emit    = 1'b1;
                        n_data  = {r_held, hv[3:0]};
                    end
                end
            end
        end

        if (emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_pos   <= '0;
            r_mismatch  <= 1'b0;
            r_held      <= 4'h0;
            r_pending   <= 1'b0;
            r_dig_err   <= 1'b0;
            r_cap_ex    <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_tag_pos   <= n_tag_pos;
            r_mismatch  <= n_mismatch;
            r_held      <= n_held;
            r_pending   <= n_pending;
            r_dig_err   <= n_dig_err;
            r_cap_ex    <= n_cap_ex;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload, loaded only when a new beat is produced.
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_kind   <= n_kind;
            r_data   <= n_data;
            r_status <= n_status;
            r_bcount <= n_bcount;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_kind;
    assign o_data_byte  = r_data;
    assign o_status     = r_status;
    assign o_byte_count = r_bcount;

`ifndef SYNTHESIS
    // The tag position stops at the tag length.
    a_tag_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tag_pos <= TAG_LEN_C)
        else $error("tag position beyond tag length");

    // The byte count never passes the line capacity.
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAPACITY_C)
        else $error("byte count beyond capacity");

    // A line end clears the line state on the next cycle.
    a_line_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_advance && i_beat.line_end) |=>
            (r_tag_pos == '0 && r_count == '0 && !r_pending && !r_mismatch))
        else $error("line state not cleared after line end");

    // A data beat is only produced after a complete, matching tag.
    a_data_after_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && n_kind == KIND_DATA) |-> (r_tag_pos == TAG_LEN_C && !r_mismatch))
        else $error("data beat without a valid tag");
`endif

endmodule

`default_nettype wire

FILE: design/prefixed_hex_line_decoder_unit.sv
// Top level of the prefixed hex line decoder.
//
// Input channel: one beat per character (i_char_code) or an end-of-line marker
// (i_line_end = 1), accepted when i_in_valid and o_in_ready are both high.
// A line must open with the tag "COAPHEX:"; after it each pair of hex digits
// yields one data beat (o_kind = 0, o_data_byte). The end-of-line marker yields
// a status beat (o_kind = 1, o_status, o_byte_count) that judges the line;
// data beats of a line whose status is not ok are to be dropped by the receiver.
// Output channel: a beat is taken when o_out_valid and i_out_ready are both high.
// An accepted beat is held in the input register, then decoded; a result beat
// that it yields loads into the result register, from which it is offered.
// Throughput: one input beat per cycle unless the receiver stalls a result beat.
// When the receiver stalls, the result register holds and the input register
// fills; o_in_ready then falls until the result is taken.
// Reset (i_rst_n low at a clock edge) empties both registers and clears the
// line state, so the next character starts a new line.
`default_nettype none

module prefixed_hex_line_decoder_unit
    import phld_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [7:0]         i_char_code,
    input  wire logic               i_line_end,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic                    o_kind,
    output logic [7:0]              o_data_byte,
    output logic [2:0]              o_status,
    output logic [COUNT_W-1:0]      o_byte_count
);

    logic       beat_valid;
    logic       advance;
    t_char_beat beat;

    // Input register.
    phld_in_stage u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_char_code  (i_char_code),
        .i_line_end   (i_line_end),
        .o_in_ready   (o_in_ready),
        .i_advance    (advance),
        .o_beat_valid (beat_valid),
        .o_beat       (beat)
    );

    // Decode and result register.
    phld_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_beat_valid (beat_valid),
        .i_beat       (beat),
        .o_advance    (advance),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_kind       (o_kind),
        .o_data_byte  (o_data_byte),
        .o_status     (o_status),
        .o_byte_count (o_byte_count)
    );

endmodule

`default_nettype wire
